[rtl/core/next_fit_block_allocator_top_defines.svh]
// ----------------------------------------------------------------------------
// next_fit_block_allocator_top_defines
// Assertion macros shared by the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, muted during reset.
`define NFBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, muted during reset.
`define NFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/nfba_pkg.sv]
// ----------------------------------------------------------------------------
// nfba_pkg
// Types and constants of the next-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package nfba_pkg;

    localparam int MAP_W  = 11;
    localparam int ADDR_W = 10;
    localparam int SIZE_W = 10;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BOUNDS   = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_HEAD,
        S_RUN,
        S_RUN_CHK,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } nfba_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } nfba_mem_ctrl_t;

    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] granted;
    } nfba_result_t;

endpackage

`default_nettype wire

[rtl/core/nfba_map_ram.sv]
// ----------------------------------------------------------------------------
// nfba_map_ram
// Block map storage: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_map_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                       aclk,
    input  wire nfba_pkg::nfba_mem_ctrl_t   ctrl,
    input  wire logic [AW-1:0]              addr,
    input  wire logic [nfba_pkg::MAP_W-1:0] wdata,
    output logic      [nfba_pkg::MAP_W-1:0] rdata
);

    logic [nfba_pkg::MAP_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[addr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/nfba_engine.sv]
// ----------------------------------------------------------------------------
// nfba_engine
// Sequencer and shared adder that walk the block map for alloc and free.
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_engine #(
    parameter int ARENA_UNITS = 1024,
    parameter int AW          = 10,
    parameter int PW          = 13
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_kind,
    input  wire logic [nfba_pkg::SIZE_W-1:0] in_size,
    input  wire logic [nfba_pkg::ADDR_W-1:0] in_addr,
    output nfba_pkg::nfba_result_t           res,
    input  wire logic                        res_ready,
    output nfba_pkg::nfba_mem_ctrl_t         mem_ctrl,
    output logic      [AW-1:0]               mem_addr,
    output logic      [nfba_pkg::MAP_W-1:0]  mem_wdata,
    input  wire logic [nfba_pkg::MAP_W-1:0]  mem_rdata
);

    localparam logic [PW-1:0] ARENA_P  = PW'(ARENA_UNITS);
    localparam logic [PW-1:0] LAST_P   = PW'(ARENA_UNITS - 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(ARENA_UNITS - 1);

    nfba_pkg::nfba_state_t state_reg, state_next;

    logic [PW-1:0]                    pos_reg, pos_next;
    logic [PW-1:0]                    run_reg, run_next;
    logic [PW-1:0]                    end_reg, end_next;
    logic [PW-1:0]                    limit_reg, limit_next;
    logic [nfba_pkg::MAP_W-1:0]       total_reg, total_next;
    logic [nfba_pkg::MAP_W-1:0]       ptr_reg, ptr_next;
    logic                             pass_reg, pass_next;
    logic [AW-1:0]                    clr_reg, clr_next;
    logic [nfba_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [nfba_pkg::STAT_W-1:0]      status_reg, status_next;
    logic [nfba_pkg::ADDR_W-1:0]      granted_reg, granted_next;

    logic [PW-1:0] alu_a, alu_b, alu_sum;
    logic [PW-1:0] ptr_ext, limit_wrap;
    logic          pass_fail;

    // bound of the wrap-around pass: up to the pointer, at most the last unit
    assign ptr_ext    = PW'(ptr_reg);
    assign limit_wrap = (ptr_ext < LAST_P) ? ptr_ext + PW'(1) : ARENA_P;

    // shared adder, operands picked by the sequencer
    always_comb begin
        alu_a = pos_reg;
        alu_b = PW'(total_reg);
        unique case (state_reg)
            nfba_pkg::S_HEAD:     alu_b = PW'(mem_rdata);
            nfba_pkg::S_RUN:      alu_b = PW'(1);
            nfba_pkg::S_RUN_CHK: begin
                alu_a = run_reg;
                alu_b = PW'(1);
            end
            nfba_pkg::S_FREE_RD: begin
                alu_a = PW'(addr_reg);
                alu_b = '1;
            end
            nfba_pkg::S_FREE_CHK: alu_b = PW'(mem_rdata);
            default: begin
                alu_a = pos_reg;
                alu_b = PW'(total_reg);
            end
        endcase
    end
    assign alu_sum = alu_a + alu_b;

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nfba_pkg::S_CLEAR;
            clr_reg   <= '0;
            ptr_reg   <= '0;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ptr_reg   <= ptr_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        run_reg     <= run_next;
        end_reg     <= end_next;
        limit_reg   <= limit_next;
        total_reg   <= total_next;
        addr_reg    <= addr_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    // next state, memory requests and result
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        run_next     = run_reg;
        end_next     = end_reg;
        limit_next   = limit_reg;
        total_next   = total_reg;
        ptr_next     = ptr_reg;
        pass_next    = pass_reg;
        clr_next     = clr_reg;
        addr_next    = addr_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        pass_fail    = 1'b0;
        in_ready     = 1'b0;
        mem_ctrl     = '0;
        mem_addr     = '0;
        mem_wdata    = '0;
        res.valid    = 1'b0;
        res.status   = status_reg;
        res.granted  = granted_reg;

        unique case (state_reg)
            // sweep zeros through the map after reset
            nfba_pkg::S_CLEAR: begin
                mem_ctrl.wr_en = 1'b1;
                mem_addr       = clr_reg;
                if (clr_reg == LAST_IDX) begin
                    state_next = nfba_pkg::S_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            nfba_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_kind == nfba_pkg::KIND_ALLOC) begin
                        total_next = nfba_pkg::MAP_W'(in_size) + nfba_pkg::MAP_W'(1);
                        pos_next   = ptr_ext;
                        limit_next = ARENA_P;
                        pass_next  = 1'b0;
                        state_next = nfba_pkg::S_CHECK;
                    end else begin
                        addr_next  = in_addr;
                        state_next = nfba_pkg::S_FREE_RD;
                    end
                end
            end
            // block must end inside the pass bound, then fetch the header
            nfba_pkg::S_CHECK: begin
                if (alu_sum > limit_reg) begin
                    pass_fail = 1'b1;
                end else begin
                    end_next       = alu_sum;
                    mem_ctrl.rd_en = 1'b1;
                    mem_addr       = pos_reg[AW-1:0];
                    state_next     = nfba_pkg::S_HEAD;
                end
            end
            // skip a whole block or start scanning a zero run
            nfba_pkg::S_HEAD: begin
                if (mem_rdata != '0) begin
                    pos_next   = alu_sum;
                    state_next = nfba_pkg::S_CHECK;
                end else begin
                    run_next   = pos_reg;
                    state_next = nfba_pkg::S_RUN;
                end
            end
            // run long enough: grant, unless the header sits on the last unit
            nfba_pkg::S_RUN: begin
                if (run_reg == end_reg) begin
                    if (pos_reg >= LAST_P) begin
                        pass_fail = 1'b1;
                    end else begin
                        mem_ctrl.wr_en = 1'b1;
                        mem_addr       = pos_reg[AW-1:0];
                        mem_wdata      = total_reg;
                        ptr_next       = end_reg[nfba_pkg::MAP_W-1:0];
                        granted_next   = alu_sum[nfba_pkg::ADDR_W-1:0];
                        status_next    = nfba_pkg::STATUS_OK;
                        state_next     = nfba_pkg::S_DONE;
                    end
                end else begin
                    mem_ctrl.rd_en = 1'b1;
                    mem_addr       = run_reg[AW-1:0];
                    state_next     = nfba_pkg::S_RUN_CHK;
                end
            end
            nfba_pkg::S_RUN_CHK: begin
                if (mem_rdata == '0) begin
                    run_next   = alu_sum;
                    state_next = nfba_pkg::S_RUN;
                end else begin
                    pos_next   = run_reg;
                    state_next = nfba_pkg::S_CHECK;
                end
            end
            // bounds check on the address, then fetch the header below it
            nfba_pkg::S_FREE_RD: begin
                granted_next = '0;
                if (addr_reg == '0 || PW'(addr_reg) > ARENA_P) begin
                    status_next = nfba_pkg::STATUS_BOUNDS;
                    state_next  = nfba_pkg::S_DONE;
                end else begin
                    pos_next       = alu_sum;
                    mem_ctrl.rd_en = 1'b1;
                    mem_addr       = alu_sum[AW-1:0];
                    state_next     = nfba_pkg::S_FREE_CHK;
                end
            end
            // drop the header if the block stays inside the arena
            nfba_pkg::S_FREE_CHK: begin
                if (alu_sum > ARENA_P) begin
                    status_next = nfba_pkg::STATUS_BOUNDS;
                end else begin
                    mem_ctrl.wr_en = 1'b1;
                    mem_addr       = pos_reg[AW-1:0];
                    status_next    = nfba_pkg::STATUS_OK;
                end
                state_next = nfba_pkg::S_DONE;
            end
            nfba_pkg::S_DONE: begin
                res.valid = 1'b1;
                if (res_ready) begin
                    state_next = nfba_pkg::S_IDLE;
                end
            end
            default: state_next = nfba_pkg::S_IDLE;
        endcase

        // pass exhausted: wrap to the arena start once, then report no space
        if (pass_fail) begin
            if (!pass_reg) begin
                pass_next  = 1'b1;
                pos_next   = '0;
                limit_next = limit_wrap;
                state_next = nfba_pkg::S_CHECK;
            end else begin
                status_next  = nfba_pkg::STATUS_NO_SPACE;
                granted_next = '0;
                state_next   = nfba_pkg::S_DONE;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/next_fit_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// next_fit_block_allocator_top
// Next-fit allocator over an arena of header-tagged blocks.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one request beat: s_kind selects allocate or free,
//   s_request_size gives payload units, s_block_address the block to free.
//   The m_ channel returns one beat per request: m_status and
//   m_granted_address (first payload unit, zero unless an allocate is ok).
//   One request is in work at a time; s_ready is low until it has finished.
//   An allocate passes S_CHECK and S_HEAD for each header skipped and S_RUN
//   and S_RUN_CHK for each free unit scanned; a wrap to the arena start adds
//   a second walk. The single map port and the shared adder set this pace.
//   A free steps through S_FREE_RD, S_FREE_CHK and S_DONE, skipping
//   S_FREE_CHK when the address is out of bounds; as its result is loaded
//   into the result register, the engine returns to idle for the next beat.
//   After reset the block sweeps zeros through the map with s_ready low;
//   the next-fit pointer starts at the arena start.
//   A finished result waits in the output register while m_ready is low, and
//   the engine holds its next result until that register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module next_fit_block_allocator_top #(
    parameter int ARENA_UNITS = 1024
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_kind,
    input  wire logic [nfba_pkg::SIZE_W-1:0]  s_request_size,
    input  wire logic [nfba_pkg::ADDR_W-1:0]  s_block_address,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [nfba_pkg::STAT_W-1:0]  m_status,
    output logic      [nfba_pkg::ADDR_W-1:0]  m_granted_address
);

    localparam int AW = $clog2(ARENA_UNITS);
    localparam int PW = $clog2(ARENA_UNITS + 2048) + 1;

    nfba_pkg::nfba_result_t     res;
    nfba_pkg::nfba_mem_ctrl_t   mem_ctrl;
    logic [AW-1:0]              mem_addr;
    logic [nfba_pkg::MAP_W-1:0] mem_wdata, mem_rdata;
    logic                       res_ready;

    logic                        m_valid_reg, m_valid_next;
    logic [nfba_pkg::STAT_W-1:0] m_status_reg;
    logic [nfba_pkg::ADDR_W-1:0] m_granted_reg;

    nfba_engine #(
        .ARENA_UNITS (ARENA_UNITS),
        .AW          (AW),
        .PW          (PW)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_kind   (s_kind),
        .in_size   (s_request_size),
        .in_addr   (s_block_address),
        .res       (res),
        .res_ready (res_ready),
        .mem_ctrl  (mem_ctrl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    nfba_map_ram #(
        .DEPTH (ARENA_UNITS),
        .AW    (AW)
    ) u_map (
        .aclk  (aclk),
        .ctrl  (mem_ctrl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res.valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid && res_ready) begin
            m_status_reg  <= res.status;
            m_granted_reg <= res.granted;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_address = m_granted_reg;

endmodule

`default_nettype wire

[rtl/core/nfba_checker.sv]
// ----------------------------------------------------------------------------
// nfba_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "next_fit_block_allocator_top_defines.svh"

module nfba_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        s_kind,
    input wire logic [nfba_pkg::SIZE_W-1:0] s_request_size,
    input wire logic [nfba_pkg::ADDR_W-1:0] s_block_address,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [nfba_pkg::STAT_W-1:0] m_status,
    input wire logic [nfba_pkg::ADDR_W-1:0] m_granted_address
);

    // hold a stalled result beat
    `NFBA_ASSERT_NEXT(a_res_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_granted_address), "stalled result beat changed")

    // go busy once a request beat is taken
    `NFBA_ASSERT_NEXT(a_busy_after_req, s_valid && s_ready, !s_ready, "ready stayed high after a request beat")

    // grant only on success
    `NFBA_ASSERT_NOW(a_grant_zero, m_valid && m_status != nfba_pkg::STATUS_OK, m_granted_address == '0, "address granted on a failed request")

    // report only defined status codes
    `NFBA_ASSERT_NOW(a_status_code, m_valid, m_status == nfba_pkg::STATUS_OK || m_status == nfba_pkg::STATUS_NO_SPACE || m_status == nfba_pkg::STATUS_BOUNDS, "undefined status code")

endmodule

bind next_fit_block_allocator_top nfba_checker u_nfba_checker (.*);

`default_nettype wire
